// ===== rtl/tlv_record_parser_macros.svh =====
// assertion helpers for the parser rtl
`ifndef TLV_RECORD_PARSER_MACROS_SVH
`define TLV_RECORD_PARSER_MACROS_SVH

// same-cycle implication
`define TLVP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLVP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tlvp_pkg.sv =====
package tlvp_pkg;

	typedef enum logic [4:0] {
		PH_COUNT = 5'b00001,
		PH_TAG   = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_VALUE = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_COUNT_TRUNC = 4'd1;
	localparam logic [3:0] ST_COUNT_BIG   = 4'd2;
	localparam logic [3:0] ST_TAG_TRUNC   = 4'd3;
	localparam logic [3:0] ST_BAD_TAG     = 4'd4;
	localparam logic [3:0] ST_DUP         = 4'd5;
	localparam logic [3:0] ST_LEN_TRUNC   = 4'd6;
	localparam logic [3:0] ST_OVERRUN     = 4'd7;
	localparam logic [3:0] ST_TRAILING    = 4'd8;

	localparam logic [1:0] CFG_MAX_TAG         = 2'd0;
	localparam logic [1:0] CFG_MAX_FIELD_COUNT = 2'd1;

	localparam logic [7:0]  MAX_TAG_RST         = 8'd57;
	localparam logic [15:0] MAX_FIELD_COUNT_RST = 16'd4096;

	localparam logic [2:0] COUNT_LAST_IDX = 3'd3;
	localparam logic [2:0] LEN_LAST_IDX   = 3'd7;

	// record epoch marks in the tag seen memory; zero marks a free entry
	localparam int                 EPOCH_W     = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

endpackage

// ===== rtl/tlv_record_parser.sv =====
// channel   signals                        direction  payload
// byte      byte_valid / byte_stall        in         data_byte, last_byte
// result    result_valid / result_stall    out        header_valid .. status
// config    cfg_we, cfg_index, cfg_data    in         max_tag, max_field_count
//
// one byte per cycle when not stalled; a byte's result is offered from the result register after the input register
// all per-byte work sits between the input register and the result register
// arst_n clears control state and sets both config registers to their reset values, then a
// clearing pass of all TAG_SPACE (256) tag seen memory entries runs with no item advancing
// the same pass runs after every 255th record, when the record epoch wraps
// result_stall holds the result register; the input register still fills behind it
module tlv_record_parser #(
	parameter int TAG_SPACE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        header_valid,
	output logic        value_valid,
	output logic [7:0]  field_tag,
	output logic [63:0] field_length,
	output logic [7:0]  value_byte,
	output logic        value_last,
	output logic        record_done,
	output logic [3:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tlvp_pkg::*;

	`include "tlv_record_parser_macros.svh"

	localparam int TAG_IDX_W = (TAG_SPACE > 1) ? $clog2(TAG_SPACE) : 1;
	localparam logic [TAG_IDX_W-1:0] CLR_LAST = TAG_IDX_W'(TAG_SPACE - 1);

	logic [7:0]  max_tag_q;
	logic [15:0] max_fc_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [EPOCH_W-1:0] seen_rd_s1;

	phase_t          phase_q, phase_n;
	logic [2:0]      idx_q, idx_n;
	logic [31:0]     fields_q, fields_n;
	logic [63:0]     vleft_q, vleft_n;
	logic [63:0]     shift_q, shift_n;
	logic [7:0]      tag_q, tag_n;
	logic [3:0]      err_q, err_n;

	logic [EPOCH_W-1:0]   seen_mem [TAG_SPACE];
	logic [EPOCH_W-1:0]   epoch_q;
	logic                 clr_q;
	logic [TAG_IDX_W-1:0] clr_idx_q;
	logic                 tag_seen;
	logic                 tag_new;
	logic                 seen_we;

	logic        hv_n, vv_n, vlast_n, done_n;
	logic [63:0] flen_n;
	logic [7:0]  vbyte_n;
	logic [3:0]  st_n;

	logic [63:0] shifted;
	logic [31:0] cnt;
	logic        bad_tag;
	logic        advance;
	logic        res_free;

	logic        res_valid_q;
	logic        hv_q, vv_q, vlast_q, done_q;
	logic [7:0]  tag_out_q, vbyte_q;
	logic [63:0] flen_q;
	logic [3:0]  st_q;

	assign res_free   = !res_valid_q || !result_stall;
	assign advance    = valid_s1 && res_free && !clr_q;
	assign byte_stall = valid_s1 && !advance;

	assign shifted = {shift_q[55:0], byte_s1};
	assign cnt     = shifted[31:0];
	assign bad_tag = (byte_s1 == 8'd0) || (byte_s1 > max_tag_q)
		|| ({1'b0, byte_s1} >= 9'(TAG_SPACE));
	assign tag_seen = (seen_rd_s1 == epoch_q);
	assign seen_we  = advance && tag_new;

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		fields_n = fields_q;
		vleft_n  = vleft_q;
		shift_n  = shift_q;
		tag_n    = tag_q;
		err_n    = err_q;
		tag_new  = 1'b0;
		hv_n     = 1'b0;
		vv_n     = 1'b0;
		vlast_n  = 1'b0;
		done_n   = 1'b0;
		flen_n   = 64'd0;
		vbyte_n  = 8'd0;
		st_n     = ST_OK;
		if (err_q == ST_OK) begin
			unique case (phase_q)
				PH_COUNT: begin
					shift_n = shifted;
					idx_n   = idx_q + 3'd1;
					if (idx_q == COUNT_LAST_IDX) begin
						idx_n   = 3'd0;
						shift_n = 64'd0;
						if (cnt > {16'd0, max_fc_q}) begin
							err_n = ST_COUNT_BIG;
						end else begin
							fields_n = cnt;
							phase_n  = (cnt == 32'd0) ? PH_DONE : PH_TAG;
						end
					end
				end
				PH_TAG: begin
					if (bad_tag) begin
						err_n = ST_BAD_TAG;
					end else if (tag_seen) begin
						err_n = ST_DUP;
					end else begin
						tag_new = 1'b1;
						tag_n   = byte_s1;
						idx_n   = 3'd0;
						shift_n = 64'd0;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					shift_n = shifted;
					idx_n   = idx_q + 3'd1;
					if (idx_q == LEN_LAST_IDX) begin
						hv_n    = 1'b1;
						flen_n  = shifted;
						idx_n   = 3'd0;
						vleft_n = shifted;
						shift_n = 64'd0;
						if (shifted == 64'd0) begin
							fields_n = fields_q - 32'd1;
							phase_n  = (fields_q == 32'd1) ? PH_DONE : PH_TAG;
						end else begin
							phase_n = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					vv_n    = 1'b1;
					vbyte_n = byte_s1;
					vleft_n = vleft_q - 64'd1;
					if (vleft_q == 64'd1) begin
						vlast_n  = 1'b1;
						fields_n = fields_q - 32'd1;
						phase_n  = (fields_q == 32'd1) ? PH_DONE : PH_TAG;
					end
				end
				PH_DONE: begin
					err_n = ST_TRAILING;
				end
				default: begin
					err_n = ST_TRAILING;
				end
			endcase
		end
		if (last_s1) begin
			done_n = 1'b1;
			if (err_n != ST_OK) begin
				st_n = err_n;
			end else begin
				case (phase_n)
					PH_COUNT: st_n = ST_COUNT_TRUNC;
					PH_TAG:   st_n = ST_TAG_TRUNC;
					PH_LEN:   st_n = ST_LEN_TRUNC;
					PH_VALUE: st_n = ST_OVERRUN;
					default:  st_n = ST_OK;
				endcase
			end
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tag_q <= MAX_TAG_RST;
			max_fc_q  <= MAX_FIELD_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MAX_TAG) begin
				max_tag_q <= cfg_data[7:0];
			end else if (cfg_index == CFG_MAX_FIELD_COUNT) begin
				max_fc_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// tag seen memory, one epoch mark per tag, read as the byte is taken
	always_ff @(posedge clk) begin
		if (clr_q) begin
			seen_mem[clr_idx_q] <= EPOCH_NONE;
		end else if (seen_we) begin
			seen_mem[byte_s1[TAG_IDX_W-1:0]] <= epoch_q;
		end
		if (byte_valid && !byte_stall) begin
			seen_rd_s1 <= seen_mem[data_byte[TAG_IDX_W-1:0]];
		end
	end

	// record epoch and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EPOCH_FIRST;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + TAG_IDX_W'(1);
			if (clr_idx_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end
		end else if (advance && last_s1) begin
			if (epoch_q == EPOCH_LAST) begin
				epoch_q   <= EPOCH_FIRST;
				clr_q     <= 1'b1;
				clr_idx_q <= '0;
			end else begin
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COUNT;
			idx_q    <= 3'd0;
			fields_q <= 32'd0;
			vleft_q  <= 64'd0;
			shift_q  <= 64'd0;
			tag_q    <= 8'd0;
			err_q    <= ST_OK;
		end else if (advance) begin
			if (last_s1) begin
				phase_q  <= PH_COUNT;
				idx_q    <= 3'd0;
				fields_q <= 32'd0;
				vleft_q  <= 64'd0;
				shift_q  <= 64'd0;
				tag_q    <= 8'd0;
				err_q    <= ST_OK;
			end else begin
				phase_q  <= phase_n;
				idx_q    <= idx_n;
				fields_q <= fields_n;
				vleft_q  <= vleft_n;
				shift_q  <= shift_n;
				tag_q    <= tag_n;
				err_q    <= err_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hv_q      <= hv_n;
			vv_q      <= vv_n;
			tag_out_q <= tag_n;
			flen_q    <= flen_n;
			vbyte_q   <= vbyte_n;
			vlast_q   <= vlast_n;
			done_q    <= done_n;
			st_q      <= st_n;
		end
	end

	assign result_valid = res_valid_q;
	assign header_valid = hv_q;
	assign value_valid  = vv_q;
	assign field_tag    = tag_out_q;
	assign field_length = flen_q;
	assign value_byte   = vbyte_q;
	assign value_last   = vlast_q;
	assign record_done  = done_q;
	assign status       = st_q;

	`TLVP_ASSERT_NOW(a_hdr_val_excl, result_valid, !(header_valid && value_valid), "hdr and value")
	`TLVP_ASSERT_NOW(a_status_done, result_valid && !record_done, status == ST_OK, "early status")
	`TLVP_ASSERT_NOW(a_vlast_vv, result_valid && value_last, value_valid, "value_last alone")
	`TLVP_ASSERT_NEXT(a_rec_clear, advance && last_s1, phase_q == PH_COUNT, "record not cleared")

endmodule
